// ===== rtl/bb3_pkg.sv =====
// Shared constants, types and helpers for the 3x3 box blur stream block.
package bb3_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int ADDR_W      = $clog2(MAX_WIDTH);
   localparam int CH_W        = 8;
   localparam int PIX_W       = 3 * CH_W;
   localparam int SUM_W       = 12;
   localparam int RECIP_W     = 21;
   localparam int RECIP_SHIFT = 20;
   localparam int WIDTH_W     = 11;
   localparam int HEIGHT_W    = 16;
   localparam int COL_W       = 10;
   localparam int CSR_IDX_W   = 8;
   localparam int CSR_DATA_W  = 16;
   localparam int RSP_DATA_W  = 56;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 8'd1;

   // Command from the controller to the datapath.
   typedef struct packed {
      logic                pix_load;
      logic                shift_en;
      logic                sum_en;
      logic                div_en;
      logic                out_load;
      logic [ADDR_W-1:0]   addr;
      logic [1:0]          row_first;
      logic [1:0]          col_first;
      logic [HEIGHT_W-1:0] out_row;
      logic [COL_W-1:0]    out_col;
      logic                last;
      logic                done;
   } bb3_cmd_type;

   typedef struct packed {
      logic out_free;
   } bb3_stat_type;

   // Reciprocal of the neighbor count, scaled by 2**RECIP_SHIFT and rounded up;
   // exact for every sum below 2**SUM_W.
   function automatic logic [RECIP_W-1:0] recip(input logic [3:0] count);
      logic [RECIP_W-1:0] m;
      begin
         case (count)
            4'd1:    m = 21'd1048576;
            4'd2:    m = 21'd524288;
            4'd3:    m = 21'd349526;
            4'd4:    m = 21'd262144;
            4'd6:    m = 21'd174763;
            4'd9:    m = 21'd116509;
            default: m = 21'd1048576;
         endcase
         recip = m;
      end
   endfunction

endpackage

// ===== rtl/bb3_ram.sv =====
// Generic single-port-write, registered-read RAM.
module bb3_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bb3_ctrl.sv =====
// Controller: configuration, position counters and result sequencing.
module bb3_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   input  logic [bb3_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bb3_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  bb3_pkg::bb3_stat_type          stat,
   output bb3_pkg::bb3_cmd_type           cmd
);
   import bb3_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_SHIFT, S_SEL, S_SUM, S_DIV, S_OUT
   } state_type;

   state_type             state_ff, state_in;
   logic [WIDTH_W-1:0]    width_ff, width_in;
   logic [HEIGHT_W-1:0]   height_ff, height_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic [HEIGHT_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]      c_ff, c_in;
   logic [HEIGHT_W-1:0]   r_ff, r_in;
   logic [3:0]            cand_ff, cand_in;
   logic [1:0]            k_ff, k_in;

   logic [WIDTH_W-1:0]    w_eff;
   logic [HEIGHT_W-1:0]   h_eff;
   logic                  row_end, last_row, accept;
   logic                  has_up, has_left, more;

   assign w_eff = (width_ff == '0) ? WIDTH_W'(1) :
                  (width_ff > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : width_ff;
   assign h_eff = (height_ff == '0) ? HEIGHT_W'(1) : height_ff;
   assign row_end  = ({1'b0, col_ff} + WIDTH_W'(1)) >= w_eff;
   assign last_row = ({1'b0, row_ff} + (HEIGHT_W+1)'(1)) >= {1'b0, h_eff};
   assign req_tready = (state_ff == S_IDLE);
   assign accept = req_tvalid && req_tready;

   // Window edges and position of the current candidate result
   always_comb begin
      has_up   = k_ff[1] ? (r_ff >= HEIGHT_W'(1)) : (r_ff >= HEIGHT_W'(2));
      has_left = k_ff[0] ? (c_ff >= COL_W'(1)) : (c_ff >= COL_W'(2));
      more     = 1'b0;
      case (k_ff)
         2'd0:    more = |cand_ff[3:1];
         2'd1:    more = |cand_ff[3:2];
         2'd2:    more = cand_ff[3];
         default: more = 1'b0;
      endcase
      cmd.pix_load  = accept;
      cmd.shift_en  = (state_ff == S_SHIFT);
      cmd.sum_en    = (state_ff == S_SUM);
      cmd.div_en    = (state_ff == S_DIV);
      cmd.out_load  = (state_ff == S_OUT) && stat.out_free;
      cmd.addr      = (state_ff == S_IDLE || state_ff == S_SHIFT) ? col_ff : c_ff;
      cmd.row_first = k_ff[1] ? (has_up ? 2'd1 : 2'd2) : (has_up ? 2'd0 : 2'd1);
      cmd.col_first = k_ff[0] ? (has_left ? 2'd1 : 2'd2) : (has_left ? 2'd0 : 2'd1);
      cmd.out_row   = k_ff[1] ? r_ff : r_ff - HEIGHT_W'(1);
      cmd.out_col   = k_ff[0] ? c_ff : c_ff - COL_W'(1);
      cmd.last      = !more;
      cmd.done      = (k_ff == 2'd3);
   end

   // Next state
   always_comb begin
      state_in  = state_ff;
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      c_in      = c_ff;
      r_in      = r_ff;
      cand_in   = cand_ff;
      k_in      = k_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            // latch the position, pick the results this pixel releases
            c_in    = col_ff;
            r_in    = row_ff;
            k_in    = 2'd0;
            cand_in[0] = (row_ff >= HEIGHT_W'(1)) && (col_ff >= COL_W'(1));
            cand_in[1] = (row_ff >= HEIGHT_W'(1)) && row_end;
            cand_in[2] = last_row && (col_ff >= COL_W'(1));
            cand_in[3] = last_row && row_end;
            if (row_end) begin
               col_in = '0;
               row_in = last_row ? '0 : row_ff + HEIGHT_W'(1);
            end else begin
               col_in = col_ff + COL_W'(1);
            end
            state_in = S_SEL;
         end
         S_SEL: begin
            if (cand_ff[k_ff]) begin
               state_in = S_SUM;
            end else if (k_ff == 2'd3) begin
               state_in = S_IDLE;
            end else begin
               k_in = k_ff + 2'd1;
            end
         end
         S_SUM: state_in = S_DIV;
         S_DIV: state_in = S_OUT;
         S_OUT: begin
            if (stat.out_free) begin
               if (k_ff == 2'd3) begin
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = S_SEL;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
      // register write restarts the image
      if (csr_valid) begin
         if (csr_index == REG_IMAGE_WIDTH) begin
            width_in = csr_data[WIDTH_W-1:0];
            col_in   = '0;
            row_in   = '0;
         end else if (csr_index == REG_IMAGE_HEIGHT) begin
            height_in = csr_data;
            col_in    = '0;
            row_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         width_ff  <= WIDTH_W'(MAX_WIDTH);
         height_ff <= HEIGHT_W'(1);
         col_ff    <= '0;
         row_ff    <= '0;
         cand_ff   <= '0;
         k_ff      <= '0;
      end else begin
         state_ff  <= state_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         cand_ff   <= cand_in;
         k_ff      <= k_in;
      end
      c_ff <= c_in;
      r_ff <= r_in;
   end

endmodule

// ===== rtl/bb3_dp.sv =====
// Datapath: line stores, 3x3 window, window sums, divide and output register.
module bb3_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  bb3_pkg::bb3_cmd_type             cmd,
   output bb3_pkg::bb3_stat_type            stat,
   input  logic [bb3_pkg::PIX_W-1:0]        req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [bb3_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tlast,
   output logic                             rsp_tuser
);
   import bb3_pkg::*;

   logic [PIX_W-1:0]    pix_ff;
   logic [PIX_W-1:0]    top_rd, mid_rd;
   logic [PIX_W-1:0]    win_ff [9];
   logic [SUM_W-1:0]    sum_in [3];
   logic [SUM_W-1:0]    sum_ff [3];
   logic [RECIP_W-1:0]  m_ff;
   logic [3:0]          count;
   logic [CH_W-1:0]     q_ff [3];
   logic [SUM_W+RECIP_W-1:0] prod [3];
   logic                valid_ff;
   logic [RSP_DATA_W-1:0] data_ff;
   logic                last_ff, done_ff;

   // Row two above takes the old row above; row above takes the new pixel
   bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_two_above (
      .clock(clock), .wr_en(cmd.shift_en), .wr_addr(cmd.addr), .wr_data(mid_rd),
      .rd_en(cmd.pix_load), .rd_addr(cmd.addr), .rd_data(top_rd)
   );
   bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_above (
      .clock(clock), .wr_en(cmd.shift_en), .wr_addr(cmd.addr), .wr_data(pix_ff),
      .rd_en(cmd.pix_load), .rd_addr(cmd.addr), .rd_data(mid_rd)
   );

   // Hold incoming pixel
   always_ff @(posedge clock) begin
      if (cmd.pix_load) begin
         pix_ff <= req_tdata;
      end
   end

   // Advance window one column
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else if (cmd.shift_en) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i*3]   <= win_ff[i*3+1];
            win_ff[i*3+1] <= win_ff[i*3+2];
         end
         win_ff[2] <= top_rd;
         win_ff[5] <= mid_rd;
         win_ff[8] <= pix_ff;
      end
   end

   // Sum in-bounds neighbors per channel
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         sum_in[ch] = '0;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               if (2'(i) >= cmd.row_first && 2'(j) >= cmd.col_first) begin
                  sum_in[ch] = sum_in[ch] + SUM_W'(win_ff[i*3+j][ch*CH_W +: CH_W]);
               end
            end
         end
      end
      count = 4'(2'd3 - cmd.row_first) * 4'(2'd3 - cmd.col_first);
   end

   always_ff @(posedge clock) begin
      if (cmd.sum_en) begin
         sum_ff <= sum_in;
         m_ff   <= recip(count);
      end
   end

   // Divide by neighbor count through the reciprocal
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         prod[ch] = (SUM_W+RECIP_W)'(sum_ff[ch]) * (SUM_W+RECIP_W)'(m_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_en) begin
         for (int ch = 0; ch < 3; ch++) begin
            q_ff[ch] <= prod[ch][RECIP_SHIFT +: CH_W];
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         data_ff <= {6'd0, cmd.out_col, cmd.out_row, q_ff[2], q_ff[1], q_ff[0]};
         last_ff <= cmd.last;
         done_ff <= cmd.done;
      end
   end

   assign stat.out_free = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = done_ff;

endmodule

// ===== rtl/box_blur_3x3_stream.sv =====
// Top level of the streaming 3x3 RGB box blur.
// Pixels enter in raster order; each result is the per-channel truncated mean of the
// in-bounds 3x3 neighborhood, tagged with row and column. Results lag one row and one
// pixel, so the last pixel of a row releases up to four results. One pixel is taken at
// a time: the controller steps each result the pixel releases through the shared sum
// and divide unit, and passes over each candidate it does not release; a stalled result
// output holds the block. Writing either register restarts the image at row 0, column 0.
// The line stores need no clearing after reset.
module box_blur_3x3_stream (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [bb3_pkg::PIX_W-1:0]      req_tdata,  // pixel_red, pixel_green, pixel_blue
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // blur_red, blur_green, blur_blue, out_row, out_col, zero fill
   output logic [bb3_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast,  // last_of_run
   output logic                           rsp_tuser,  // image_done
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bb3_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bb3_pkg::CSR_DATA_W-1:0] csr_data
);
   import bb3_pkg::*;

   bb3_cmd_type  cmd;
   bb3_stat_type stat;

   assign csr_ready = 1'b1;

   bb3_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_index(csr_index), .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .stat(stat), .cmd(cmd)
   );

   bb3_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser)
   );

endmodule

// ===== rtl/bb3_checker.sv =====
// Port-level checks for the box blur stream, bound to the top level.
module bb3_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [bb3_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tlast,
   input logic                           rsp_tuser
);
   import bb3_pkg::*;

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Image end is always the last result of its pixel
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("image_done without last_of_run");

   // One pixel at a time: busy right after a transaction
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("pixel taken while busy");

   // Padding bits stay zero
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:50] == '0)
      else $error("nonzero padding");

endmodule

bind box_blur_3x3_stream bb3_checker u_bb3_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser)
);

// ===== dv/tb_top.sv =====
// Self-checking testbench for the streaming 3x3 RGB box blur.
`timescale 1ns / 1ps

module tb_top;
   import bb3_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 30;
   localparam int HOLD_CYCLES    = 400;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [15:0] row;
      logic [9:0]  col;
      logic        last;
      logic        done;
   } blur_result_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [PIX_W-1:0]      req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tuser;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // Predictor state
   logic [PIX_W-1:0]    line_above [MAX_WIDTH];
   logic [PIX_W-1:0]    line_two_above [MAX_WIDTH];
   logic [PIX_W-1:0]    window [9];
   int unsigned         col_pos, row_pos;
   logic [WIDTH_W-1:0]  width_reg;
   logic [HEIGHT_W-1:0] height_reg;

   blur_result_type expected_blur[$];
   idle_mode_type   idle_mode;
   int              error_count, pixels_sent, results_checked, configs_written;
   int              quiet_cycles;
   logic            hold_output;

   box_blur_3x3_stream u_top (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report(input string what);
      $display("ERROR at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // Average the in-bounds window around center (cr, cc)
   function automatic blur_result_type blur_at(input int cr, input int cc, input bit has_up,
                                               input bit has_left, input int orow,
                                               input int ocol, input bit done);
      blur_result_type res;
      int r0, c0, r1, c1, sr, sg, sb, n;
      r0 = has_up ? cr - 1 : cr;
      c0 = has_left ? cc - 1 : cc;
      r1 = (cr == 1) ? 2 : cr;
      c1 = (cc == 1) ? 2 : cc;
      sr = 0; sg = 0; sb = 0; n = 0;
      for (int i = r0; i <= r1; i++) begin
         for (int j = c0; j <= c1; j++) begin
            sr += window[i*3+j][7:0];
            sg += window[i*3+j][15:8];
            sb += window[i*3+j][23:16];
            n++;
         end
      end
      res.red   = 8'(sr / n);
      res.green = 8'(sg / n);
      res.blue  = 8'(sb / n);
      res.row   = 16'(orow);
      res.col   = 10'(ocol);
      res.last  = 1'b0;
      res.done  = done;
      return res;
   endfunction

   // Advance the predictor by one pixel and queue the results it releases
   task automatic predict_blur(input logic [PIX_W-1:0] px);
      int unsigned w, h, c, r;
      logic [PIX_W-1:0] top, mid;
      bit row_end, last_row;
      blur_result_type batch[$];
      w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
      h = (height_reg == 0) ? 1 : height_reg;
      c = col_pos;
      r = row_pos;
      top = line_two_above[c];
      mid = line_above[c];
      row_end = (c + 1 >= w);
      last_row = (r + 1 >= h);
      line_two_above[c] = mid;
      line_above[c] = px;
      for (int i = 0; i < 3; i++) begin
         window[i*3] = window[i*3+1];
         window[i*3+1] = window[i*3+2];
      end
      window[2] = top;
      window[5] = mid;
      window[8] = px;
      if (r >= 1 && c >= 1) batch.push_back(blur_at(1, 1, r >= 2, c >= 2, r-1, c-1, 0));
      if (r >= 1 && row_end) batch.push_back(blur_at(1, 2, r >= 2, c >= 1, r-1, c, 0));
      if (last_row && c >= 1) batch.push_back(blur_at(2, 1, r >= 1, c >= 2, r, c-1, 0));
      if (last_row && row_end) batch.push_back(blur_at(2, 2, r >= 1, c >= 1, r, c, 1));
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[k]) expected_blur.push_back(batch[k]);
      if (row_end) begin
         col_pos = 0;
         row_pos = last_row ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endtask

   // Predict on input and register transactions, check each result transaction
   always @(posedge clock) begin
      blur_result_type got, want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_IMAGE_WIDTH) width_reg = csr_data[WIDTH_W-1:0];
            else if (csr_index == REG_IMAGE_HEIGHT) height_reg = csr_data;
            col_pos = 0;
            row_pos = 0;
            configs_written++;
         end
         if (req_tvalid && req_tready) predict_blur(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16], rsp_tdata[39:24],
                   rsp_tdata[49:40], rsp_tlast, rsp_tuser};
            if (expected_blur.size() == 0) begin
               report($sformatf("unexpected result %h", got));
            end else begin
               want = expected_blur.pop_front();
               if (got.red !== want.red) report($sformatf("red %h exp %h", got.red, want.red));
               if (got.green !== want.green)
                  report($sformatf("green %h exp %h", got.green, want.green));
               if (got.blue !== want.blue)
                  report($sformatf("blue %h exp %h", got.blue, want.blue));
               if (got.row !== want.row) report($sformatf("row %0d exp %0d", got.row, want.row));
               if (got.col !== want.col) report($sformatf("col %0d exp %0d", got.col, want.col));
               if (got.last !== want.last) report($sformatf("tlast %b exp %b", got.last, want.last));
               if (got.done !== want.done) report($sformatf("tuser %b exp %b", got.done, want.done));
               if (rsp_tdata[55:50] !== 6'd0) report("nonzero fill in rsp_tdata");
            end
            results_checked++;
         end
      end
   end

   // Drive the result-side ready, with an occasional long hold-off
   always @(posedge clock) begin
      int held;
      if (reset) begin
         rsp_tready <= 1'b0;
         held = 0;
      end else if (hold_output && held < HOLD_CYCLES) begin
         rsp_tready <= 1'b0;
         held++;
      end else begin
         if (hold_output) begin
            hold_output <= 1'b0;
            held = 0;
         end
         case (idle_mode)
            IDLE_RECEIVER: rsp_tready <= ($urandom_range(99) >= 85);
            IDLE_BOTH:     rsp_tready <= ($urandom_range(99) >= 22);
            default:       rsp_tready <= 1'b1;
         endcase
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired after %0d idle cycles", quiet_cycles);
         $display("box_blur_3x3_stream: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Send one pixel, with sender gaps per the idle mode; valid stays high after
   task automatic send_pixel(input logic [PIX_W-1:0] px);
      int pct;
      pct = (idle_mode == IDLE_SENDER) ? 85 : (idle_mode == IDLE_BOTH) ? 22 : 0;
      if ($urandom_range(99) < pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      do @(posedge clock); while (!req_tready);
      pixels_sent++;
   endtask

   task automatic stop_sending();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // Hold until every expected result has arrived, then let the block settle
   task automatic drain();
      stop_sending();
      while (expected_blur.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic set_size(input int w, input int h);
      write_reg(REG_IMAGE_WIDTH, w);
      write_reg(REG_IMAGE_HEIGHT, h);
   endtask

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++) send_pixel(PIX_W'($urandom));
   endtask

   // Single-pixel image, a 3x3 image of alternating extreme values, zero sizes, a tall 2-wide image
   task automatic test_directed();
      idle_mode = IDLE_NONE;
      set_size(1, 1);
      send_pixel(24'hFFFFFF);
      send_pixel(24'h000000);
      set_size(3, 3);
      for (int i = 0; i < 9; i++) send_pixel((i % 2) ? 24'hFFFFFF : 24'h000000);
      set_size(0, 0);
      send_pixel(24'hA5C3FF);
      set_size(2, 65535);
      send_random(6);
   endtask

   // Widths above the maximum are taken as the maximum row length
   task automatic test_wide_row();
      idle_mode = IDLE_NONE;
      set_size(2047, 1);
      send_random(8);
      set_size(1024, 1);
      send_random(4);
   endtask

   // Stall the output long enough for the input to back up
   task automatic test_backpressure();
      idle_mode = IDLE_NONE;
      set_size(4, 3);
      hold_output <= 1'b1;
      send_random(24);
      drain();
   endtask

   // Pause mid-image until every result is out, then continue
   task automatic test_pause();
      idle_mode = IDLE_SENDER;
      set_size(3, 4);
      send_random(5);
      drain();
      send_random(7);
   endtask

   // Images of random sizes and content under each idle mode, now and then cut short after w + 2 pixels
   task automatic test_random_images();
      int w, h, sent;
      for (int m = 0; m < 4; m++) begin
         idle_mode = idle_mode_type'(m);
         sent = 0;
         while (sent < 42) begin
            w = $urandom_range(1, 7);
            h = $urandom_range(1, 5);
            set_size(w, h);
            if ($urandom_range(9) == 0) begin
               send_random(w + 2);
               sent += w + 2;
            end else begin
               send_random(w * h);
               sent += w * h;
            end
         end
      end
      idle_mode = IDLE_NONE;
   endtask

   initial begin
      int waited;
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      hold_output = 1'b0;
      idle_mode = IDLE_NONE;
      error_count = 0;
      pixels_sent = 0;
      results_checked = 0;
      configs_written = 0;
      quiet_cycles = 0;
      col_pos = 0;
      row_pos = 0;
      width_reg = WIDTH_W'(MAX_WIDTH);
      height_reg = HEIGHT_W'(1);
      foreach (window[i]) window[i] = '0;
      foreach (line_above[i]) begin
         line_above[i] = '0;
         line_two_above[i] = '0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_backpressure();
      test_pause();
      test_random_images();
      test_wide_row();

      stop_sending();
      waited = 0;
      while (expected_blur.size() != 0 && waited < WATCHDOG_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_blur.size() != 0)
         report($sformatf("%0d results never arrived", expected_blur.size()));
      $display("Covered %0d pixels, %0d blurred results, %0d register writes,",
               pixels_sent, results_checked, configs_written);
      $display("sizes from 1x1 to over-wide rows, under all idle and stall modes.");
      if (error_count == 0) begin
         $display("box_blur_3x3_stream: match");
      end else begin
         $display("box_blur_3x3_stream: mismatch");
      end
      $finish;
   end

endmodule
